/* src/tlst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tlst_pkg;

  localparam int ENTRIES    = 16;
  localparam int TAG_BITS   = 16;
  localparam int DUR_BITS   = 32;
  localparam int TOTAL_BITS = 48;
  localparam int COUNT_BITS = 32;
  localparam int SLOT_BITS  = 4;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_MATCH = 2'd1,
    FSM_WRITE = 2'd2
  } fsm_t;

  // Broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic                match;
    logic                write;
    logic                clear;
    logic                none_hit;
    logic [TAG_BITS-1:0] tag;
    logic [DUR_BITS-1:0] dur;
  } cell_cmd_t;

  // Updated statistics of a cell, all zero unless the cell was selected.
  typedef struct packed {
    logic                  sel;
    logic [COUNT_BITS-1:0] count;
    logic [TOTAL_BITS-1:0] total;
    logic [DUR_BITS-1:0]   min0;
    logic [DUR_BITS-1:0]   min1;
    logic [DUR_BITS-1:0]   max0;
    logic [DUR_BITS-1:0]   max1;
  } cell_res_t;

endpackage
`default_nettype wire

/* src/tlst_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module tlst_cell
  import tlst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_cmd_t cmd,
  input  wire logic      prev_used,
  output logic           used,
  output logic           hit,
  output cell_res_t      res
);

  logic [TAG_BITS-1:0]   tag;
  logic [TOTAL_BITS-1:0] total;
  logic [COUNT_BITS-1:0] count;
  logic [DUR_BITS-1:0]   min0, min1, max0, max1;

  logic                  claim, sel;
  logic [TOTAL_BITS:0]   sum;
  logic [TOTAL_BITS-1:0] total_next;
  logic [COUNT_BITS-1:0] count_next;
  logic [DUR_BITS-1:0]   min0_next, min1_next, max0_next, max1_next;

  // The free cell is the first unused one: its left neighbour is in use.
  assign claim = cmd.none_hit && !used && prev_used;
  assign sel   = cmd.write && !cmd.clear && (hit || claim);

  always_comb begin
    sum        = {1'b0, total} + {{(TOTAL_BITS + 1 - DUR_BITS){1'b0}}, cmd.dur};
    total_next = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
    count_next = (count == {COUNT_BITS{1'b1}}) ? count : count + 1'b1;
    min0_next  = min0;
    min1_next  = min1;
    max0_next  = max0;
    max1_next  = max1;
    if (cmd.dur < min0) begin
      min1_next = min0;
      min0_next = cmd.dur;
    end else if (cmd.dur < min1) begin
      min1_next = cmd.dur;
    end
    if (cmd.dur > max0) begin
      max1_next = max0;
      max0_next = cmd.dur;
    end else if (cmd.dur > max1) begin
      max1_next = cmd.dur;
    end
    res       = '0;
    if (sel) begin
      res.sel   = 1'b1;
      res.count = count_next;
      res.total = total_next;
      res.min0  = min0_next;
      res.min1  = min1_next;
      res.max0  = max0_next;
      res.max1  = max1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= 1'b0;
      hit   <= 1'b0;
      total <= '0;
      count <= '0;
      min0  <= '1;
      min1  <= '1;
      max0  <= '0;
      max1  <= '0;
    end else begin
      if (cmd.match) begin
        hit <= used && (tag == cmd.tag);
      end
      if (cmd.write) begin
        if (cmd.clear) begin
          total <= '0;
          count <= '0;
          min0  <= '1;
          min1  <= '1;
          max0  <= '0;
          max1  <= '0;
        end else if (sel) begin
          total <= total_next;
          count <= count_next;
          min0  <= min0_next;
          min1  <= min1_next;
          max0  <= max0_next;
          max1  <= max1_next;
          if (claim) begin
            used <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && !cmd.clear && claim) begin
      tag <= cmd.tag;
    end
  end

endmodule
`default_nettype wire

/* src/tagged_latency_stats_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// A transaction is taken while the sequencer is idle, then passes through the tag
// match and entry update steps; the update waits until the output register is free.
// The sequencer takes a new transaction only after it has returned to idle, and a
// stalled result delays the update step.
// Reset (synchronous, active high) frees every entry and restores all
// statistics to their empty values; tag storage is left as it is.
module tagged_latency_stats_table_unit
  import tlst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  operation,
  input  wire logic [15:0]           tag_id,
  input  wire logic [31:0]           duration,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 status,
  output logic [3:0]                 slot,
  output logic [31:0]                call_count,
  output logic [47:0]                total_time,
  output logic [31:0]                min_first,
  output logic [31:0]                min_second,
  output logic [31:0]                max_first,
  output logic [31:0]                max_second
);

  // Sequencer state and the captured transaction.
  fsm_t                state, state_next;
  op_t                 op_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [DUR_BITS-1:0] dur_q;

  cell_cmd_t           cmd;
  logic [ENTRIES-1:0]  used_vec;
  logic [ENTRIES-1:0]  hit_vec;
  cell_res_t           res_vec [ENTRIES];
  logic                any_hit;
  logic                write_go;
  logic                accept;

  cell_res_t           res_sel;
  logic [SLOT_BITS-1:0] slot_sel;
  status_t             status_next;

  assign in_ready = (state == FSM_IDLE);
  assign accept   = in_valid && in_ready;
  assign any_hit  = |hit_vec;
  // The result register must be free (or draining) before the row is written,
  // so that the entries and the reported result always move together.
  assign write_go = (state == FSM_WRITE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.tag      = tag_q;
    cmd.dur      = dur_q;
    cmd.clear    = (op_q == OP_CLEAR);
    cmd.none_hit = !any_hit;
    case (state)
      FSM_IDLE: begin
        if (accept) begin
          state_next = FSM_MATCH;
        end
      end
      FSM_MATCH: begin
        cmd.match  = 1'b1;
        state_next = FSM_WRITE;
      end
      FSM_WRITE: begin
        if (write_go) begin
          cmd.write  = 1'b1;
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op_t'(operation);
      tag_q <= tag_id[TAG_BITS-1:0];
      dur_q <= duration[DUR_BITS-1:0];
    end
  end

  // The row of cells. Each cell learns from its left neighbour whether it is
  // the first free entry; the leftmost cell treats its missing neighbour as used.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic prev_used;
    if (i == 0) begin : g_first
      assign prev_used = 1'b1;
    end else begin : g_rest
      assign prev_used = used_vec[i-1];
    end
    tlst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .prev_used (prev_used),
      .used      (used_vec[i]),
      .hit       (hit_vec[i]),
      .res       (res_vec[i])
    );
  end

  // At most one cell is selected, so its result and index are gathered by OR.
  always_comb begin
    res_sel  = '0;
    slot_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      res_sel = res_sel | res_vec[i];
      if (res_vec[i].sel) begin
        slot_sel = slot_sel | SLOT_BITS'(i);
      end
    end
    if (op_q == OP_CLEAR) begin
      status_next = ST_CLEARED;
    end else if (any_hit) begin
      status_next = ST_UPDATED;
    end else if (!used_vec[ENTRIES-1]) begin
      status_next = ST_INSERTED;
    end else begin
      status_next = ST_DROPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (write_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Cleared and dropped transactions report zeros, which the OR of
  // unselected cells gives naturally.
  always_ff @(posedge clk) begin
    if (write_go) begin
      status     <= status_next;
      slot       <= slot_sel;
      call_count <= res_sel.count;
      total_time <= res_sel.total;
      min_first  <= res_sel.min0;
      min_second <= res_sel.min1;
      max_first  <= res_sel.max0;
      max_second <= res_sel.max1;
    end
  end

endmodule
`default_nettype wire

/* src/tlst_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module tlst_checker
  import tlst_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [3:0]  slot,
  input wire logic [31:0] call_count,
  input wire logic [47:0] total_time,
  input wire logic [31:0] min_first,
  input wire logic [31:0] min_second,
  input wire logic [31:0] max_first,
  input wire logic [31:0] max_second
);

  logic zero_fields;
  assign zero_fields = (slot == '0) && (call_count == '0) && (total_time == '0) &&
                       (min_first == '0) && (min_second == '0) &&
                       (max_first == '0) && (max_second == '0);

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(total_time))
    else $error("result changed while stalled");

  // Only one transaction is in the block at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken too early");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_CLEARED || status == ST_DROPPED) |-> zero_fields)
    else $error("cleared or dropped result carries statistics");

  // A recorded call always leaves at least one call and ordered extremes.
  a_record_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_UPDATED || status == ST_INSERTED) |->
      (call_count != '0) && (min_first <= min_second) && (max_first >= max_second) &&
      (min_first <= max_first))
    else $error("recorded statistics inconsistent");

endmodule

bind tagged_latency_stats_table_unit tlst_checker u_tlst_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .slot       (slot),
  .call_count (call_count),
  .total_time (total_time),
  .min_first  (min_first),
  .min_second (min_second),
  .max_first  (max_first),
  .max_second (max_second)
);
`default_nettype wire

/* tb/tagged_latency_stats_table_unit_tb.sv */
`timescale 1ns / 1ps
module tagged_latency_stats_table_unit_tb;
  import tlst_pkg::*;

  // Cycles in which neither channel completes a transaction before the run is
  // declared hung. The longest legitimate gap is a random idle or stall
  // stretch, plus the pipeline latency and the short wait at the end.
  localparam int unsigned HANG_LIMIT = 4000;
  localparam int unsigned RANDOM_PER_PHASE = 275;

  typedef struct packed {
    op_t         op;
    logic [15:0] tag;
    logic [31:0] dur;
  } work_item_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [31:0] count;
    logic [47:0] total;
    logic [31:0] min0;
    logic [31:0] min1;
    logic [31:0] max0;
    logic [31:0] max1;
  } entry_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [15:0] tag_id = '0;
  logic [31:0] duration = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [3:0]  slot;
  logic [31:0] call_count;
  logic [47:0] total_time;
  logic [31:0] min_first;
  logic [31:0] min_second;
  logic [31:0] max_first;
  logic [31:0] max_second;

  tagged_latency_stats_table_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .tag_id     (tag_id),
    .duration   (duration),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .slot       (slot),
    .call_count (call_count),
    .total_time (total_time),
    .min_first  (min_first),
    .min_second (min_second),
    .max_first  (max_first),
    .max_second (max_second)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Items waiting to be offered, and the reports still owed by the block.
  work_item_t    pending_q[$];
  entry_report_t report_q[$];
  work_item_t    offered;

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls; the stimulus process changes them between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Our own copy of the table. Claimed slots are never released, as reset is
  // applied only once at the start of the run.
  int unsigned claimed = 0;
  logic [15:0] tag_of[ENTRIES];
  logic [31:0] calls_of[ENTRIES];
  logic [47:0] sum_of[ENTRIES];
  logic [31:0] fastest[ENTRIES];
  logic [31:0] second_fastest[ENTRIES];
  logic [31:0] slowest[ENTRIES];
  logic [31:0] second_slowest[ENTRIES];

  // Tags that the directed part claims, in slot order.
  logic [15:0] known_tags[ENTRIES];

  function automatic void clear_tallies();
    for (int i = 0; i < ENTRIES; i++) begin
      calls_of[i]       = '0;
      sum_of[i]         = '0;
      fastest[i]        = '1;
      second_fastest[i] = '1;
      slowest[i]        = '0;
      second_slowest[i] = '0;
    end
  endfunction

  // Applies one transaction to the table copy and returns the report that the
  // block must produce for it.
  function automatic entry_report_t tally(work_item_t item);
    entry_report_t r;
    int unsigned   hit;
    bit            found;
    logic [48:0]   sum;
    r     = '0;
    hit   = 0;
    found = 1'b0;
    if (item.op == OP_CLEAR) begin
      clear_tallies();
      r.status = ST_CLEARED;
      return r;
    end
    // The lowest claimed slot holding the tag wins.
    for (int i = 0; i < claimed; i++) begin
      if (!found && tag_of[i] == item.tag) begin
        found = 1'b1;
        hit   = i;
      end
    end
    if (found) begin
      r.status = ST_UPDATED;
    end else if (claimed < ENTRIES) begin
      hit         = claimed;
      tag_of[hit] = item.tag;
      claimed++;
      r.status = ST_INSERTED;
    end else begin
      // Unknown tag with no free slot: nothing changes.
      r.status = ST_DROPPED;
      return r;
    end

    sum = {1'b0, sum_of[hit]} + 49'(item.dur);
    sum_of[hit] = sum[48] ? '1 : sum[47:0];
    if (calls_of[hit] != '1) calls_of[hit] = calls_of[hit] + 1'b1;

    // A new extreme pushes the old one into second place; a tie with the
    // first extreme may still improve the second.
    if (item.dur < fastest[hit]) begin
      second_fastest[hit] = fastest[hit];
      fastest[hit]        = item.dur;
    end else if (item.dur < second_fastest[hit]) begin
      second_fastest[hit] = item.dur;
    end
    if (item.dur > slowest[hit]) begin
      second_slowest[hit] = slowest[hit];
      slowest[hit]        = item.dur;
    end else if (item.dur > second_slowest[hit]) begin
      second_slowest[hit] = item.dur;
    end

    r.slot  = hit[3:0];
    r.count = calls_of[hit];
    r.total = sum_of[hit];
    r.min0  = fastest[hit];
    r.min1  = second_fastest[hit];
    r.max0  = slowest[hit];
    r.max1  = second_slowest[hit];
    return r;
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Driver: a new item is offered only when the previous one has been taken
  // or none was offered, so valid and the payload hold steady until accepted.
  // The expected report is worked out at the edge on which the transaction
  // completes.
  always @(posedge clk) begin
    work_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        report_q.push_back(tally(offered));
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          offered   <= nxt;
          in_valid  <= 1'b1;
          operation <= nxt.op;
          tag_id    <= nxt.tag;
          duration  <= nxt.dur;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every completed result transaction is matched against the
  // oldest outstanding report, field by field.
  always @(posedge clk) begin
    entry_report_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, actual status %0h",
                   $time, status);
        end else begin
          want = report_q.pop_front();
          check_field("status", want.status, status);
          check_field("slot", want.slot, slot);
          check_field("call_count", want.count, call_count);
          check_field("total_time", want.total, total_time);
          check_field("min_first", want.min0, min_first);
          check_field("min_second", want.min1, min_second);
          check_field("max_first", want.max0, max_first);
          check_field("max_second", want.max1, max_second);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: the run is declared hung after too long without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("tagged_latency_stats_table_unit_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(op_t op, logic [15:0] tag, logic [31:0] dur);
    work_item_t item;
    item.op  = op;
    item.tag = tag;
    item.dur = dur;
    pending_q.push_back(item);
  endtask

  // Sets the idling for a phase and holds further stimulus back until the
  // block has delivered every outstanding report. Sampling on the falling
  // edge keeps this clear of the clocked processes.
  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || report_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned pick;
    logic [15:0] tag;
    logic [31:0] dur;

    clear_tallies();
    known_tags[0] = 16'h0000;
    known_tags[1] = 16'hFFFF;
    for (int i = 2; i < ENTRIES; i++) known_tags[i] = 16'h0100 + 16'(i) * 16'h0111;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The extreme tags and durations claim the first two
    // slots, then ties with the current extremes are exercised.
    push_item(OP_RECORD, known_tags[0], 32'h0000_0000);
    push_item(OP_RECORD, known_tags[1], 32'hFFFF_FFFF);
    push_item(OP_RECORD, known_tags[0], 32'h0000_0000);  // ties the minimum once
    push_item(OP_RECORD, known_tags[0], 32'h0000_0000);  // ties both minima
    push_item(OP_RECORD, known_tags[1], 32'hFFFF_FFFF);  // ties the maximum
    push_item(OP_RECORD, known_tags[0], 32'd7);
    push_item(OP_RECORD, known_tags[0], 32'd3);
    push_item(OP_RECORD, known_tags[0], 32'd9);
    // A clear wipes the statistics; the next record on a known tag must
    // still find its old slot.
    push_item(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    push_item(OP_RECORD, known_tags[0], 32'd5);
    // Fill the table to the last slot, then offer a tag that has no room.
    for (int i = 2; i < ENTRIES; i++) push_item(OP_RECORD, known_tags[i], $urandom);
    push_item(OP_RECORD, 16'h7777, 32'h1234_5678);
    push_item(OP_RECORD, known_tags[ENTRIES-1], 32'h8000_0000);
    push_item(OP_CLEAR, 16'h0000, 32'h0000_0000);
    run_phase(0, 0);

    // Random part. The table is full from here on, so most records name a
    // known tag; the rest are arbitrary tags that are mostly dropped, with
    // the occasional clear thrown in.
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        case ($urandom_range(5))
          0:       dur = $urandom_range(15);
          1:       dur = 32'hFFFF_FFFF - $urandom_range(15);
          2, 3:    dur = $urandom;
          default: dur = $urandom_range(1000);
        endcase
        if (pick < 3) begin
          push_item(OP_CLEAR, 16'($urandom), $urandom);
        end else begin
          tag = (pick < 88) ? known_tags[$urandom_range(ENTRIES-1)] : 16'($urandom);
          push_item(OP_RECORD, tag, dur);
        end
      end
      case (phase)
        0:       run_phase(0, 0);
        1:       run_phase(55, 0);
        2:       run_phase(0, 55);
        default: run_phase(32, 32);
      endcase
    end

    // Allow for stray results after the last expected one.
    repeat (20) @(posedge clk);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("tagged_latency_stats_table_unit_tb: done, clean");
    end else begin
      $display("tagged_latency_stats_table_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
